@@ src/e2q_pkg.sv @@
// ----------------------------------------------------------------------------
// e2q_pkg: shared types and constants for the euler to quaternion block
// widths, cordic arctangent table and order sign patterns
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam int ZW = 28;   // angle accumulator, q.24 in [-8,8)
    localparam int XW = 28;   // cordic x/y, q.24

    localparam logic signed [ZW-1:0] PI_Q24      = 28'sd52707179;
    localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [XW-1:0] GAIN_Q24    = 28'sd10188014;
    localparam logic signed [17:0]   Q16_ONE     = 18'sd65536;
    localparam logic signed [15:0]   Q14_MAX     = 16'sd16384;

    typedef enum logic [2:0] {
        ORD_XYZ = 3'd0,
        ORD_YXZ = 3'd1,
        ORD_ZXY = 3'd2,
        ORD_ZYX = 3'd3,
        ORD_YZX = 3'd4,
        ORD_XZY = 3'd5
    } t_order;

    typedef logic signed [15:0] t_q14;
    typedef logic signed [17:0] t_q16;

    typedef struct packed {
        t_q16 s;
        t_q16 c;
    } t_sincos;

    function automatic logic signed [ZW-1:0] atan_q24(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0:  r = 28'sd13176795;
            1:  r = 28'sd7778716;
            2:  r = 28'sd4110060;
            3:  r = 28'sd2086331;
            4:  r = 28'sd1047214;
            5:  r = 28'sd524117;
            6:  r = 28'sd262123;
            7:  r = 28'sd131069;
            default: r = ZW'(28'sd65536 >>> (i - 8));
        endcase
        return r;
    endfunction

    // minus flags for x, y, z, w; unused codes give zero output elsewhere
    function automatic logic [3:0] minus_pattern(input logic [2:0] ord);
        logic [3:0] m;
        unique case (ord)
            ORD_XYZ: m = 4'b0101;
            ORD_YXZ: m = 4'b0110;
            ORD_ZXY: m = 4'b1001;
            ORD_ZYX: m = 4'b1010;
            ORD_YZX: m = 4'b0011;
            ORD_XZY: m = 4'b1100;
            default: m = 4'b0000;
        endcase
        return m;
    endfunction

endpackage

@@ src/e2q_if.sv @@
// ----------------------------------------------------------------------------
// e2q channel interfaces
// valid/ready channels for the angle input and quaternion output
// ----------------------------------------------------------------------------
interface e2q_in_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic [2:0]         rotation_order;
    modport source (output valid, angle_x, angle_y, angle_z, rotation_order, input ready);
    modport sink   (input valid, angle_x, angle_y, angle_z, rotation_order, output ready);
endinterface

interface e2q_out_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

@@ src/e2q_cordic.sv @@
// ----------------------------------------------------------------------------
// e2q_cordic: pipelined half-angle sine/cosine
// fold stage, one register per cordic iteration, q.16 rounding stage
// ----------------------------------------------------------------------------
module e2q_cordic (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [15:0]    i_angle,
    output e2q_pkg::t_sincos      o_sc
);
    import e2q_pkg::*;

    logic signed [XW-1:0] r_x [CORDIC_STEPS+1];
    logic signed [XW-1:0] r_y [CORDIC_STEPS+1];
    logic signed [ZW-1:0] r_z [CORDIC_STEPS+1];
    logic                 r_flip [CORDIC_STEPS+1];
    logic signed [ZW-1:0] n_t;
    logic                 n_flip;
    logic signed [ZW-1:0] t0;
    t_sincos              r_out;

    function automatic t_q16 to_q16(input logic signed [XW-1:0] v, input logic f);
        logic signed [XW:0] a;
        logic signed [XW:0] r;
        a = f ? -(XW+1)'(v) : (XW+1)'(v);
        r = (a + (XW+1)'(128)) >>> 8;
        if (r > (XW+1)'(Q16_ONE))       r = (XW+1)'(Q16_ONE);
        else if (r < -(XW+1)'(Q16_ONE)) r = -(XW+1)'(Q16_ONE);
        return r[17:0];
    endfunction

    // quadrant folding into [-pi/2, pi/2]
    always_comb begin
        t0 = ZW'(i_angle) <<< 11;
        n_t = t0;
        n_flip = 1'b0;
        if (t0 > HALF_PI_Q24) begin
            n_t = t0 - PI_Q24;
            n_flip = 1'b1;
        end else if (t0 < -HALF_PI_Q24) begin
            n_t = t0 + PI_Q24;
            n_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= GAIN_Q24;
            r_y[0] <= '0;
            r_z[0] <= n_t;
            r_flip[0] <= n_flip;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][ZW-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_q24(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_q24(i);
                end
                r_flip[i+1] <= r_flip[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.c <= to_q16(r_x[CORDIC_STEPS], r_flip[CORDIC_STEPS]);
            r_out.s <= to_q16(r_y[CORDIC_STEPS], r_flip[CORDIC_STEPS]);
        end
    end

    assign o_sc = r_out;
endmodule

@@ src/e2q_combine.sv @@
// ----------------------------------------------------------------------------
// e2q_combine: triple products, signed sum, round and saturate
// two multiply stages, an add stage and a rounding stage
// ----------------------------------------------------------------------------
module e2q_combine (
    input  logic              i_clk,
    input  logic              i_en,
    input  e2q_pkg::t_sincos  i_a,
    input  e2q_pkg::t_sincos  i_b,
    input  e2q_pkg::t_sincos  i_c,
    input  logic [2:0]        i_order,
    output e2q_pkg::t_q14     o_q [4]
);
    import e2q_pkg::*;

    // products in each component: p1 = f0*f1*f2, p2 = g0*g1*g2
    logic signed [35:0] r_pf [4];
    logic signed [35:0] r_pg [4];
    t_q16               r_f2 [4];
    t_q16               r_g2 [4];
    logic signed [53:0] r_p1 [4];
    logic signed [53:0] r_p2 [4];
    logic signed [54:0] r_sum [4];
    t_q14               r_q [4];
    logic [3:0]         r_m0, r_m1;
    logic               r_z0, r_z1, r_z2;
    t_q16 f0 [4], f1 [4], f2 [4], g0 [4], g1 [4], g2 [4];

    always_comb begin
        f0[0] = i_a.s; f1[0] = i_b.c; f2[0] = i_c.c;
        g0[0] = i_a.c; g1[0] = i_b.s; g2[0] = i_c.s;
        f0[1] = i_a.c; f1[1] = i_b.s; f2[1] = i_c.c;
        g0[1] = i_a.s; g1[1] = i_b.c; g2[1] = i_c.s;
        f0[2] = i_a.c; f1[2] = i_b.c; f2[2] = i_c.s;
        g0[2] = i_a.s; g1[2] = i_b.s; g2[2] = i_c.c;
        f0[3] = i_a.c; f1[3] = i_b.c; f2[3] = i_c.c;
        g0[3] = i_a.s; g1[3] = i_b.s; g2[3] = i_c.s;
    end

    function automatic t_q14 round_sat(input logic signed [54:0] s, input logic zero);
        logic signed [54:0] r;
        r = (s + (55'sd1 <<< 33)) >>> 34;
        if (zero)                      r = '0;
        else if (r > 55'(Q14_MAX))     r = 55'(Q14_MAX);
        else if (r < -55'(Q14_MAX))    r = -55'(Q14_MAX);
        return r[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r_pf[k] <= f0[k] * f1[k];
                r_pg[k] <= g0[k] * g1[k];
                r_f2[k] <= f2[k];
                r_g2[k] <= g2[k];
                r_p1[k] <= r_pf[k] * r_f2[k];
                r_p2[k] <= r_pg[k] * r_g2[k];
                // pattern msb is the x component, lsb is w
                r_sum[k] <= r_m1[3-k] ? 55'(r_p1[k]) - 55'(r_p2[k])
                                      : 55'(r_p1[k]) + 55'(r_p2[k]);
                r_q[k] <= round_sat(r_sum[k], r_z2);
            end
            // order codes above the last valid one give an all-zero result
            r_m0 <= minus_pattern(i_order);
            r_z0 <= (i_order > 3'(ORD_XZY));
            r_m1 <= r_m0;
            r_z1 <= r_z0;
            r_z2 <= r_z1;
        end
    end

    assign o_q = r_q;
endmodule

@@ src/euler_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// euler_to_quaternion: euler angles to unit quaternion, six axis orders
// three cordic pipelines for the half angles feed a product pipeline
// ----------------------------------------------------------------------------
//  channel  dir  payload                                  width
//  i_in     in   angle_x, angle_y, angle_z, rotation_order 16/16/16/3
//  o_out    out  quat_x, quat_y, quat_z, quat_w            16 each
//
// one transaction per cycle unless stalled; the stages are fold, 20 cordic
// iterations, q.16 rounding, two multiply stages, add, round/saturate
// the pipeline advances as one; it stalls only when the output register
// is full and not taken, so in.ready = !out.valid || out.ready
// reset clears the valid bits only; payload registers are not reset
module euler_to_quaternion (
    input  logic   i_clk,
    input  logic   i_rst_n,
    e2q_in_if.sink    i_in,
    e2q_out_if.source o_out
);
    import e2q_pkg::*;

    localparam int LAT = CORDIC_STEPS + 6;

    logic         adv;
    logic [LAT-1:0] r_vld;
    logic [2:0]   r_ord [CORDIC_STEPS+2];
    t_sincos      sc_x, sc_y, sc_z;
    t_q14         q [4];

    // whole pipeline moves when the last stage is empty or drained
    assign adv = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    // order code rides alongside the cordic stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ord[0] <= i_in.rotation_order;
            for (int k = 1; k < CORDIC_STEPS + 2; k++) r_ord[k] <= r_ord[k-1];
        end
    end

    e2q_cordic u_cx (.i_clk, .i_en(adv), .i_angle(i_in.angle_x), .o_sc(sc_x));
    e2q_cordic u_cy (.i_clk, .i_en(adv), .i_angle(i_in.angle_y), .o_sc(sc_y));
    e2q_cordic u_cz (.i_clk, .i_en(adv), .i_angle(i_in.angle_z), .o_sc(sc_z));

    e2q_combine u_comb (
        .i_clk,
        .i_en    (adv),
        .i_a     (sc_x),
        .i_b     (sc_y),
        .i_c     (sc_z),
        .i_order (r_ord[CORDIC_STEPS+1]),
        .o_q     (q)
    );

    assign o_out.valid  = r_vld[LAT-1];
    assign o_out.quat_x = q[0];
    assign o_out.quat_y = q[1];
    assign o_out.quat_z = q[2];
    assign o_out.quat_w = q[3];
endmodule

@@ src/e2q_checker.sv @@
// ----------------------------------------------------------------------------
// e2q_checker: port-level checks on the euler to quaternion block
// handshake, stall and output range properties
// ----------------------------------------------------------------------------
module e2q_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               o_out_valid,
    input logic               o_out_ready,
    input logic signed [15:0] o_quat_x,
    input logic signed [15:0] o_quat_w
);
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || o_out_ready) |-> i_in_ready) else $error("ready low while free");
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_ready) |=> o_out_valid) else $error("result dropped");
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_ready) |=> $stable(o_quat_x)) else $error("result changed");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_quat_w <= 16'sd16384 && o_quat_w >= -16'sd16384))
        else $error("w out of range");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid) else $error("valid after reset");
endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .o_out_valid (o_out.valid),
    .o_out_ready (o_out.ready),
    .o_quat_x    (o_out.quat_x),
    .o_quat_w    (o_out.quat_w)
);

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench for euler_to_quaternion
// drives angle triples and axis orders with random gaps and output stalls,
// and checks every quaternion against a typed value or a bit-exact cordic predictor
// ----------------------------------------------------------------------------
module tb;
    import e2q_pkg::*;

    localparam int LATENCY = 26;
    localparam int N_RANDOM = 400;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic [2:0]         ord;
        logic               known;  // expected quaternion typed in below
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
    } t_stim_row;

    typedef struct {
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
    } t_quat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    e2q_in_if  in_ch ();
    e2q_out_if out_ch ();

    euler_to_quaternion DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_quat expected_quats[$];
    int    n_errors = 0;
    int    n_checked = 0;
    bit    stim_done = 1'b0;

    // floor shift, same as >>> on a signed 64-bit value
    function automatic longint floor_shift(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint round_q16(input longint v24);
        longint r;
        r = floor_shift(v24 + 128, 8);
        if (r > 65536) r = 65536;
        if (r < -65536) r = -65536;
        return r;
    endfunction

    // sine and cosine of half the angle, q.16
    task automatic half_angle_sincos(input logic signed [15:0] raw,
                                     output longint s, output longint c);
        longint t, x, y, z, xs, ys, a;
        bit     flip;
        t = longint'(raw) * 2048;
        flip = 1'b0;
        if (t > longint'(HALF_PI_Q24)) begin
            t -= longint'(PI_Q24);
            flip = 1'b1;
        end else if (t < -longint'(HALF_PI_Q24)) begin
            t += longint'(PI_Q24);
            flip = 1'b1;
        end
        x = longint'(GAIN_Q24);
        y = 0;
        z = t;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            case (i)
                0: a = 13176795;  1: a = 7778716;  2: a = 4110060;  3: a = 2086331;
                4: a = 1047214;   5: a = 524117;   6: a = 262123;   7: a = 131069;
                default: a = 64'sd65536 >>> (i - 8);
            endcase
            if (z >= 0) begin
                x = x - ys;  y = y + xs;  z = z - a;
            end else begin
                x = x + ys;  y = y - xs;  z = z + a;
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = round_q16(x);
        s = round_q16(y);
    endtask

    function automatic logic signed [15:0] round_q14(input longint p1, input longint p2,
                                                     input bit minus);
        longint r;
        r = floor_shift((minus ? p1 - p2 : p1 + p2) + (64'sd1 <<< 33), 34);
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    task automatic predict_quat(input logic signed [15:0] ax, input logic signed [15:0] ay,
                                input logic signed [15:0] az, input logic [2:0] ord,
                                output t_quat q);
        longint s1, c1, s2, c2, s3, c3;
        logic [3:0] m;
        q = '{default: '0};
        if (ord > ORD_XZY) return;  // unused codes give an all-zero quaternion
        case (t_order'(ord))
            ORD_XYZ: m = 4'b0101;
            ORD_YXZ: m = 4'b0110;
            ORD_ZXY: m = 4'b1001;
            ORD_ZYX: m = 4'b1010;
            ORD_YZX: m = 4'b0011;
            default: m = 4'b1100;
        endcase
        half_angle_sincos(ax, s1, c1);
        half_angle_sincos(ay, s2, c2);
        half_angle_sincos(az, s3, c3);
        q.qx = round_q14(s1 * c2 * c3, c1 * s2 * s3, m[3]);
        q.qy = round_q14(c1 * s2 * c3, s1 * c2 * s3, m[2]);
        q.qz = round_q14(c1 * c2 * s3, s1 * s2 * c3, m[1]);
        q.qw = round_q14(c1 * c2 * c3, s1 * s2 * s3, m[0]);
    endtask

    // directed rows: zero angles give the identity, unused codes give zero, the rest are predicted
    t_stim_row directed_rows[] = '{
        '{16'sd0, 16'sd0, 16'sd0, ORD_XYZ, 1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd16384},
        '{16'sd0, 16'sd0, 16'sd0, ORD_ZYX, 1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd16384},
        '{16'sd1234, -16'sd77, 16'sd9000, 3'd6, 1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{-16'sd32768, 16'sd32767, 16'sd0, 3'd7, 1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd32767, 16'sd32767, 16'sd32767, ORD_XYZ, 1'b0, 0, 0, 0, 0},
        '{-16'sd32768, -16'sd32768, -16'sd32768, ORD_YXZ, 1'b0, 0, 0, 0, 0},
        '{16'sd32767, -16'sd32768, 16'sd6434, ORD_ZXY, 1'b0, 0, 0, 0, 0},
        '{16'sd6434, 16'sd6433, -16'sd6434, ORD_ZYX, 1'b0, 0, 0, 0, 0},
        '{16'sd12868, -16'sd12868, 16'sd12869, ORD_YZX, 1'b0, 0, 0, 0, 0},
        '{16'sd12867, 16'sd1, -16'sd1, ORD_XZY, 1'b0, 0, 0, 0, 0},
        '{16'sd3000, 16'sd5000, -16'sd7000, ORD_XYZ, 1'b0, 0, 0, 0, 0},
        '{16'sd3000, 16'sd5000, -16'sd7000, ORD_YXZ, 1'b0, 0, 0, 0, 0},
        '{16'sd3000, 16'sd5000, -16'sd7000, ORD_ZXY, 1'b0, 0, 0, 0, 0},
        '{16'sd3000, 16'sd5000, -16'sd7000, ORD_ZYX, 1'b0, 0, 0, 0, 0},
        '{16'sd3000, 16'sd5000, -16'sd7000, ORD_YZX, 1'b0, 0, 0, 0, 0},
        '{16'sd3000, 16'sd5000, -16'sd7000, ORD_XZY, 1'b0, 0, 0, 0, 0},
        '{-16'sd12868, 16'sd0, 16'sd0, ORD_XYZ, 1'b0, 0, 0, 0, 0}
    };

    // push one angle transaction, after a random gap
    task automatic send_angles(input logic signed [15:0] ax, input logic signed [15:0] ay,
                               input logic signed [15:0] az, input logic [2:0] ord,
                               input bit known, input t_quat typed);
        t_quat q;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.angle_x        <= ax;
        in_ch.angle_y        <= ay;
        in_ch.angle_z        <= az;
        in_ch.rotation_order <= ord;
        do @(posedge i_clk); while (!in_ch.ready);
        if (known) q = typed;
        else predict_quat(ax, ay, az, ord, q);
        expected_quats.push_back(q);
    endtask

    initial begin
        t_quat typed;
        logic signed [15:0] ax, ay, az;
        in_ch.valid          = 1'b0;
        in_ch.angle_x        = '0;
        in_ch.angle_y        = '0;
        in_ch.angle_z        = '0;
        in_ch.rotation_order = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[k]) begin
            typed = '{directed_rows[k].qx, directed_rows[k].qy,
                      directed_rows[k].qz, directed_rows[k].qw};
            send_angles(directed_rows[k].ax, directed_rows[k].ay, directed_rows[k].az,
                        directed_rows[k].ord, directed_rows[k].known, typed);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            ax = 16'($urandom);
            ay = 16'($urandom);
            az = 16'($urandom);
            // mostly real pose angles within one turn, some anywhere in range
            if ($urandom_range(0, 3) != 0) begin
                ax = $signed(16'($urandom_range(0, 25736))) - 16'sd12868;
                ay = $signed(16'($urandom_range(0, 25736))) - 16'sd12868;
                az = $signed(16'($urandom_range(0, 25736))) - 16'sd12868;
            end
            send_angles(ax, ay, az,
                        ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                    : 3'($urandom_range(0, 5)),
                        1'b0, typed);
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // output side: random stall per transaction, with stall-free stretches
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk iff out_ch.valid);
        end
    end

    // compare each quaternion transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_quat e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_quats.size() == 0) begin
                $display("%0t: unexpected quaternion x=%0d y=%0d z=%0d w=%0d", $time,
                         out_ch.quat_x, out_ch.quat_y, out_ch.quat_z, out_ch.quat_w);
                n_errors++;
            end else begin
                e = expected_quats.pop_front();
                n_checked++;
                if (out_ch.quat_x !== e.qx || out_ch.quat_y !== e.qy ||
                    out_ch.quat_z !== e.qz || out_ch.quat_w !== e.qw) begin
                    $display("%0t: quaternion mismatch expected %0d %0d %0d %0d actual %0d %0d %0d %0d",
                             $time, e.qx, e.qy, e.qz, e.qw, out_ch.quat_x,
                             out_ch.quat_y, out_ch.quat_z, out_ch.quat_w);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        while (expected_quats.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        $display("checked %0d quaternions over all six axis orders and the unused codes",
                 n_checked);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // generous time limit for about 420 items, allowing for the largest gaps and stalls
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
